[design/pbc_pkg.sv]
// Shared types and constants for the bitplane to chunky converter.
package pbc_pkg;

    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 16;
    localparam int NUM_PLANES = 4;
    localparam int PIX_W      = 4;
    localparam int PIX_CNT_W  = 4;
    localparam int BYTE_IDX_W = 3;
    localparam int CHUNK_BYTES = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam int PLANES_W = 3;
    localparam int CPL_W    = 7;
    localparam int PAD_W    = 4;
    localparam int LPF_W    = 10;

    localparam logic [PLANES_W-1:0] PLANES_RST = 3'd4;
    localparam logic [CPL_W-1:0]    CPL_RST    = 7'd20;
    localparam logic [PAD_W-1:0]    PAD_RST    = 4'd0;
    localparam logic [LPF_W-1:0]    LPF_RST    = 10'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLANE_COUNT     = 2'd0,
        REG_CHUNKS_PER_LINE = 2'd1,
        REG_PAD_BYTES       = 2'd2,
        REG_LINES_PER_FRAME = 2'd3
    } cfg_reg_t;

    // One finished chunk handed from the front end to the pixel emitter
    typedef struct packed {
        logic [NUM_PLANES-1:0][WORD_W-1:0] words;
        logic                              line_end;
        logic                              frame_end;
    } chunk_t;

endpackage

[design/pbc_ifs.sv]
// Valid/ready channel interfaces for memory bytes and pixel results.
interface pbc_byte_if;
    logic                          valid;
    logic                          ready;
    logic [pbc_pkg::BYTE_W-1:0]    mem_byte;

    modport source (output valid, output mem_byte, input ready);
    modport sink   (input valid, input mem_byte, output ready);
endinterface

interface pbc_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [pbc_pkg::PIX_W-1:0]     pixel_index;
    logic                          chunk_end;
    logic                          line_end;
    logic                          frame_end;

    modport source (output valid, output pixel_index, output chunk_end,
                    output line_end, output frame_end, input ready);
    modport sink   (input valid, input pixel_index, input chunk_end,
                    input line_end, input frame_end, output ready);
endinterface

[design/pbc_front.sv]
// Front end: config registers, padding skip, chunk gathering and line/frame counting.
module pbc_front #(
    parameter int MAX_CHUNKS = 64,
    parameter int MAX_LINES  = 512
) (
    input  logic                             clk,
    input  logic                             rst_n,
    pbc_byte_if.sink                         bytes,
    input  logic                             cfg_wr_en,
    input  logic [pbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pbc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output logic                             push,
    output pbc_pkg::chunk_t                  push_chunk,
    input  logic                             fifo_full
);

    localparam int CW = $clog2(MAX_CHUNKS + 1);
    localparam int LW = $clog2(MAX_LINES + 1);

    logic [pbc_pkg::PLANES_W-1:0]   plane_count_reg;
    logic [pbc_pkg::CPL_W-1:0]      chunks_per_line_reg;
    logic [pbc_pkg::PAD_W-1:0]      pad_bytes_reg;
    logic [pbc_pkg::LPF_W-1:0]      lines_per_frame_reg;

    logic [pbc_pkg::BYTE_W-1:0]     bytes_reg [pbc_pkg::CHUNK_BYTES];
    logic [pbc_pkg::BYTE_IDX_W-1:0] byte_in_chunk_reg, byte_in_chunk_next;
    logic [CW-1:0]                  chunk_in_line_reg, chunk_in_line_next;
    logic [pbc_pkg::PAD_W-1:0]      pad_left_reg, pad_left_next;
    logic [LW-1:0]                  line_in_frame_reg, line_in_frame_next;

    logic [pbc_pkg::PLANES_W-1:0]   planes_eff;
    logic [pbc_pkg::BYTE_IDX_W:0]   chunk_len;
    logic [pbc_pkg::BYTE_IDX_W:0]   byte_inc;
    logic [CW:0]                    cpl_eff;
    logic [CW:0]                    chunk_inc;
    logic [LW:0]                    lpf_eff;
    logic [LW:0]                    line_inc;
    logic                           padding;
    logic                           completes;
    logic                           accept;
    logic                           line_done;
    logic                           frame_done;
    logic [pbc_pkg::BYTE_W-1:0]     cur_bytes [pbc_pkg::CHUNK_BYTES];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_count_reg     <= pbc_pkg::PLANES_RST;
            chunks_per_line_reg <= pbc_pkg::CPL_RST;
            pad_bytes_reg       <= pbc_pkg::PAD_RST;
            lines_per_frame_reg <= pbc_pkg::LPF_RST;
        end
        else if (cfg_wr_en)
        begin
            case (pbc_pkg::cfg_reg_t'(cfg_index))
                pbc_pkg::REG_PLANE_COUNT:
                    plane_count_reg <= cfg_wdata[pbc_pkg::PLANES_W-1:0];
                pbc_pkg::REG_CHUNKS_PER_LINE:
                    chunks_per_line_reg <= cfg_wdata[pbc_pkg::CPL_W-1:0];
                pbc_pkg::REG_PAD_BYTES:
                    pad_bytes_reg <= cfg_wdata[pbc_pkg::PAD_W-1:0];
                pbc_pkg::REG_LINES_PER_FRAME:
                    lines_per_frame_reg <= cfg_wdata[pbc_pkg::LPF_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Effective sizes: zero acts as one, oversize clamps
    always_comb
    begin
        if (plane_count_reg == '0)
            planes_eff = 3'd1;
        else if (plane_count_reg > 3'd4)
            planes_eff = 3'd4;
        else
            planes_eff = plane_count_reg;

        if (chunks_per_line_reg == '0)
            cpl_eff = (CW+1)'(1);
        else if (32'(chunks_per_line_reg) > MAX_CHUNKS)
            cpl_eff = (CW+1)'(MAX_CHUNKS);
        else
            cpl_eff = (CW+1)'(chunks_per_line_reg);

        if (lines_per_frame_reg == '0)
            lpf_eff = (LW+1)'(1);
        else if (32'(lines_per_frame_reg) > MAX_LINES)
            lpf_eff = (LW+1)'(MAX_LINES);
        else
            lpf_eff = (LW+1)'(lines_per_frame_reg);
    end

    assign chunk_len = {planes_eff, 1'b0};
    assign byte_inc  = {1'b0, byte_in_chunk_reg} + 4'd1;
    assign padding   = (pad_left_reg != '0);
    assign completes = !padding && (byte_inc >= chunk_len);

    // Stall only when this byte would finish a chunk and the queue is full
    assign bytes.ready = !(completes && fifo_full);
    assign accept      = bytes.valid && bytes.ready;
    assign push        = accept && completes;

    assign chunk_inc  = {1'b0, chunk_in_line_reg} + (CW+1)'(1);
    assign line_inc   = {1'b0, line_in_frame_reg} + (LW+1)'(1);
    assign line_done  = (chunk_inc >= cpl_eff);
    assign frame_done = line_done && (line_inc >= lpf_eff);

    // Current chunk bytes with the incoming byte merged in
    always_comb
    begin
        for (int p = 0; p < pbc_pkg::CHUNK_BYTES; p++)
        begin
            if (pbc_pkg::BYTE_IDX_W'(p) == byte_in_chunk_reg)
                cur_bytes[p] = bytes.mem_byte;
            else
                cur_bytes[p] = bytes_reg[p];
        end
    end

    // Plane words, absent planes read as zero
    always_comb
    begin
        push_chunk.line_end  = line_done;
        push_chunk.frame_end = frame_done;
        for (int k = 0; k < pbc_pkg::NUM_PLANES; k++)
        begin
            if (k < int'(planes_eff))
                push_chunk.words[k] = {cur_bytes[2*k], cur_bytes[2*k+1]};
            else
                push_chunk.words[k] = '0;
        end
    end

    // Byte store
    always_ff @(posedge clk)
    begin
        if (accept && !padding)
            bytes_reg[byte_in_chunk_reg] <= bytes.mem_byte;
    end

    // Counter next values
    always_comb
    begin
        byte_in_chunk_next = byte_in_chunk_reg;
        chunk_in_line_next = chunk_in_line_reg;
        pad_left_next      = pad_left_reg;
        line_in_frame_next = line_in_frame_reg;
        if (accept)
        begin
            if (padding)
                pad_left_next = pad_left_reg - 4'd1;
            else if (!completes)
                byte_in_chunk_next = byte_inc[pbc_pkg::BYTE_IDX_W-1:0];
            else
            begin
                byte_in_chunk_next = '0;
                if (line_done)
                begin
                    chunk_in_line_next = '0;
                    pad_left_next      = pad_bytes_reg;
                    if (frame_done)
                        line_in_frame_next = '0;
                    else
                        line_in_frame_next = line_inc[LW-1:0];
                end
                else
                    chunk_in_line_next = chunk_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_in_chunk_reg <= '0;
            chunk_in_line_reg <= '0;
            pad_left_reg      <= '0;
            line_in_frame_reg <= '0;
        end
        else
        begin
            byte_in_chunk_reg <= byte_in_chunk_next;
            chunk_in_line_reg <= chunk_in_line_next;
            pad_left_reg      <= pad_left_next;
            line_in_frame_reg <= line_in_frame_next;
        end
    end

endmodule

[design/pbc_fifo.sv]
// Two-entry chunk queue between the front end and the pixel emitter.
module pbc_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pbc_pkg::chunk_t push_chunk,
    output logic            full,
    output logic            pop_valid,
    input  logic            pop,
    output pbc_pkg::chunk_t pop_chunk
);

    pbc_pkg::chunk_t mem_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_chunk = mem_reg[rd_ptr_reg];

    // Storage write
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_chunk;
    end

    // Pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[design/pbc_back.sv]
// Back end: shifts a chunk's plane words out as 16 pixels into an output register.
module pbc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop,
    input  pbc_pkg::chunk_t pop_chunk,
    pbc_pixel_if.source     pixels
);

    logic [pbc_pkg::NUM_PLANES-1:0][pbc_pkg::WORD_W-1:0] shift_reg;
    logic                              line_end_reg;
    logic                              frame_end_reg;
    logic                              busy_reg, busy_next;
    logic [pbc_pkg::PIX_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                              out_valid_reg, out_valid_next;
    logic [pbc_pkg::PIX_W-1:0]         pix_reg;
    logic                              chunk_end_reg;
    logic                              out_line_reg;
    logic                              out_frame_reg;
    logic                              advance;
    logic                              last;
    logic                              emit;
    logic [pbc_pkg::PIX_W-1:0]         pix_cur;

    assign advance = !out_valid_reg || pixels.ready;
    assign last    = (cnt_reg == '1);
    assign emit    = advance && busy_reg;
    // Load the next chunk as soon as the current one gives up its last pixel
    assign pop     = pop_valid && (!busy_reg || (emit && last));

    always_comb
    begin
        for (int k = 0; k < pbc_pkg::NUM_PLANES; k++)
            pix_cur[k] = shift_reg[k][pbc_pkg::WORD_W-1];
    end

    // Control next state
    always_comb
    begin
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = busy_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (emit)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (last)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Shift register and output payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            shift_reg     <= pop_chunk.words;
            line_end_reg  <= pop_chunk.line_end;
            frame_end_reg <= pop_chunk.frame_end;
        end
        else if (emit)
        begin
            for (int k = 0; k < pbc_pkg::NUM_PLANES; k++)
                shift_reg[k] <= {shift_reg[k][pbc_pkg::WORD_W-2:0], 1'b0};
        end
        if (emit)
        begin
            pix_reg       <= pix_cur;
            chunk_end_reg <= last;
            out_line_reg  <= last && line_end_reg;
            out_frame_reg <= last && frame_end_reg;
        end
    end

    assign pixels.valid       = out_valid_reg;
    assign pixels.pixel_index = pix_reg;
    assign pixels.chunk_end   = chunk_end_reg;
    assign pixels.line_end    = out_line_reg;
    assign pixels.frame_end   = out_frame_reg;

endmodule

[design/interleaved_bitplane_to_chunky.sv]
// Top level: interleaved bitplane memory bytes in, chunky pixel indices out.
//
// Bitmap bytes are taken one per transfer in address order. Once the last byte
// of a chunk (2 bytes per plane) arrives, the chunk goes into a two-entry queue
// and the back end emits its 16 pixels, one per cycle unless the pixel output
// stalls, left pixel first. The pixel emitter sets the rate, so the average
// byte rate grows with the plane count. Padding bytes and bytes inside a chunk
// are taken every cycle; a chunk-completing byte waits only while both queue
// entries are occupied. Configuration writes take effect on the next cycle and
// should be made while the block is idle.
module interleaved_bitplane_to_chunky #(
    parameter int MAX_CHUNKS = 64,
    parameter int MAX_LINES  = 512
) (
    input  logic                             clk,
    input  logic                             rst_n,
    pbc_byte_if.sink                         bytes,
    pbc_pixel_if.source                      pixels,
    input  logic                             cfg_wr_en,
    input  logic [pbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pbc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic            push;
    logic            full;
    logic            pop;
    logic            pop_valid;
    pbc_pkg::chunk_t push_chunk;
    pbc_pkg::chunk_t pop_chunk;

    pbc_front #(
        .MAX_CHUNKS (MAX_CHUNKS),
        .MAX_LINES  (MAX_LINES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .push_chunk (push_chunk),
        .fifo_full  (full)
    );

    pbc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_chunk (push_chunk),
        .full       (full),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_chunk  (pop_chunk)
    );

    pbc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_chunk  (pop_chunk),
        .pixels     (pixels)
    );

endmodule
